@@ sv/mlfq_pkg.sv @@
// Shared types and constants for the three-level feedback queue scheduler.
`default_nettype none
package mlfq_pkg;
  localparam int unsigned QuantumW = 10;
  localparam int unsigned WorkW    = 16;
  localparam int unsigned IdW      = 6;
  localparam int unsigned PctW     = 7;
  localparam int unsigned BurstW   = 15;
  localparam int unsigned EvW      = 3;
  localparam int unsigned LvlW     = 2;

  localparam logic [QuantumW-1:0] QuantumReset   = 10'd50;
  localparam logic [QuantumW-1:0] AllotmentReset = 10'd200;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_BOOST    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [EvW-1:0] {
    EV_ADDED    = 3'd0,
    EV_REQUEUED = 3'd1,
    EV_DEMOTED  = 3'd2,
    EV_FINISHED = 3'd3,
    EV_IDLE     = 3'd4,
    EV_BOOSTED  = 3'd5,
    EV_BUSY     = 3'd6
  } event_e;

  localparam logic [0:0] CfgQuantum   = 1'b0;
  localparam logic [0:0] CfgAllotment = 1'b1;

  // Divider handshake.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ sv/mlfq_divider.sv @@
// Bit-serial restoring remainder unit: rem = dividend mod divisor.
`default_nettype none
module mlfq_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mlfq_pkg::div_req_t          req_i,
  input  wire logic [mlfq_pkg::BurstW-1:0] dividend_i,
  input  wire logic [mlfq_pkg::WorkW-1:0]  divisor_i,
  output mlfq_pkg::div_rsp_t               rsp_o,
  output logic [mlfq_pkg::WorkW-1:0]       rem_o
);
  import mlfq_pkg::*;

  logic [BurstW-1:0] dvd_q, dvd_d;
  logic [WorkW:0]    rem_q, rem_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [WorkW:0]    shifted;
  logic [WorkW:0]    diff;

  // One quotient bit per cycle.
  always_comb begin
    shifted = {rem_q[WorkW-1:0], dvd_q[BurstW-1]};
    diff    = shifted - {1'b0, divisor_i};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 4'(BurstW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[BurstW-2:0], 1'b0};
      rem_d = diff[WorkW] ? shifted : diff;
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q[WorkW-1:0];
endmodule
`default_nettype wire

@@ sv/mlfq_task_scheduler_unit.sv @@
// Top level of the three-level feedback queue task scheduler.
// Add, dispatch and boost step through their own states to the result word, an unknown
// command straight to it. A dispatch whose io draw hits also runs the remainder unit; a
// boost moves levels 2 and 3 to level 1. One command at a time; busy is high meanwhile.
// The result shows for one cycle on done_o; the receiver cannot stall.
// Reset clears the queues, the busy table and the registers to 50 and 200.
`default_nettype none
module mlfq_task_scheduler_unit #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [mlfq_pkg::QuantumW-1:0] cfg_data_i,
  input  wire logic [1:0]                    command_i,
  input  wire logic [mlfq_pkg::IdW-1:0]      task_id_i,
  input  wire logic [mlfq_pkg::WorkW-1:0]    task_length_i,
  input  wire logic [mlfq_pkg::PctW-1:0]     io_chance_i,
  input  wire logic [mlfq_pkg::PctW-1:0]     io_draw_i,
  input  wire logic [mlfq_pkg::BurstW-1:0]   burst_draw_i,
  output logic                               done_o,
  output logic [mlfq_pkg::IdW-1:0]           served_task_o,
  output logic [mlfq_pkg::WorkW-1:0]         run_time_o,
  output logic [mlfq_pkg::EvW-1:0]           event_res_o,
  output logic [mlfq_pkg::LvlW-1:0]          new_level_o
);
  import mlfq_pkg::*;

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_PICK, S_RDTASK, S_CALC, S_DIV, S_WRITE, S_BST_POP, S_BST_PUSH, S_DONE
  } state_e;

  // Configuration registers.
  logic [QuantumW-1:0] quantum_q, allot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumReset;
      allot_q   <= AllotmentReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgQuantum:   quantum_q <= cfg_data_i;
        CfgAllotment: allot_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end
  logic [QuantumW-1:0] q_eff, a_eff;
  assign q_eff = (quantum_q == '0) ? QuantumW'(1) : quantum_q;
  assign a_eff = (allot_q == '0) ? QuantumW'(1) : allot_q;

  // Memories: three queues and per-slot task records.
  logic [AW-1:0]       fifo_mem [3][MAX_TASKS];
  logic [WorkW-1:0]    total_mem [MAX_TASKS];
  logic [WorkW-1:0]    done_mem  [MAX_TASKS];
  logic [QuantumW-1:0] allot_mem [MAX_TASKS];
  logic [LvlW-1:0]     lvl_mem   [MAX_TASKS];
  logic [PctW-1:0]     pct_mem   [MAX_TASKS];
  logic [MAX_TASKS-1:0] slot_busy_q;

  logic [AW-1:0] head_q [3];
  logic [CW-1:0] count_q [3];

  state_e        state_q;
  logic [1:0]    cmd_q;
  logic [IdW-1:0] id_q;
  logic [WorkW-1:0] len_q;
  logic [PctW-1:0] chance_q, draw_q;
  logic [BurstW-1:0] burst_q;
  logic [1:0]    qsel_q;
  logic [AW-1:0] task_q;
  logic [WorkW-1:0] tot_q, wd_q, left_q, run_q;
  logic [QuantumW-1:0] al_q;
  logic [LvlW-1:0] lvl_q;
  logic [PctW-1:0] pct_q;
  logic [IdW-1:0]  res_task_q;
  logic [WorkW-1:0] res_run_q;
  logic [EvW-1:0]  res_ev_q;
  logic [LvlW-1:0] res_lvl_q;
  logic            done_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [WorkW-1:0] div_rem;

  mlfq_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req),
    .dividend_i(burst_q), .divisor_i(run_q), .rsp_o(div_rsp), .rem_o(div_rem)
  );

  logic id_ok;
  assign id_ok = (MAX_TASKS >= 64) ? 1'b1 : (32'(id_q) < MAX_TASKS);

  // Queue read of the selected head (used for pick and boost).
  logic [AW-1:0] head_slot;
  assign head_slot = fifo_mem[qsel_q][head_q[qsel_q]];

  // Compare datapath for dispatch: minimum of quantum, allotment and work left.
  logic [WorkW-1:0] mn1, mn2, al_ext;
  assign al_ext = WorkW'((al_q == '0) ? QuantumW'(1) : al_q);
  assign mn1 = (WorkW'(q_eff) < al_ext) ? WorkW'(q_eff) : al_ext;
  assign mn2 = (mn1 < left_q) ? mn1 : left_q;

  // Tail index; head plus count stays below twice the depth.
  function automatic logic [AW-1:0] tail_of(logic [AW-1:0] h, logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(h) + c;
    return (s >= CW'(MAX_TASKS)) ? AW'(s - CW'(MAX_TASKS)) : AW'(s);
  endfunction

  function automatic logic [AW-1:0] inc(logic [AW-1:0] h);
    logic [CW-1:0] s;
    s = CW'(h) + CW'(1);
    return (s == CW'(MAX_TASKS)) ? '0 : AW'(s);
  endfunction

  logic [WorkW-1:0] run_final;
  logic [QuantumW-1:0] al_after;
  assign run_final = run_q;
  assign al_after  = QuantumW'(al_ext - run_q);

  // Io cut: load the remainder unit once the minimum is known.
  always_comb begin
    div_req.start = (state_q == S_WRITE) && (run_q == '0) && (draw_q <= pct_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= command_i; id_q <= task_id_i; len_q <= task_length_i;
      chance_q <= io_chance_i; draw_q <= io_draw_i; burst_q <= burst_draw_i;
    end
    unique case (state_q)
      S_ADD: if (id_ok && !slot_busy_q[AW'(id_q)]) begin
        total_mem[AW'(id_q)] <= len_q;
        done_mem[AW'(id_q)]  <= '0;
        allot_mem[AW'(id_q)] <= a_eff;
        lvl_mem[AW'(id_q)]   <= LvlW'(1);
        pct_mem[AW'(id_q)]   <= chance_q;
        if (count_q[0] < CW'(MAX_TASKS))
          fifo_mem[0][tail_of(head_q[0], count_q[0])] <= AW'(id_q);
      end
      S_PICK: task_q <= head_slot;
      S_RDTASK: begin
        tot_q <= total_mem[task_q];
        wd_q  <= done_mem[task_q];
        al_q  <= allot_mem[task_q];
        lvl_q <= lvl_mem[task_q];
        pct_q <= pct_mem[task_q];
      end
      S_CALC: begin
        left_q <= (tot_q > wd_q) ? tot_q - wd_q : '0;
      end
      S_BST_POP: task_q <= head_slot;
      S_BST_PUSH: begin
        allot_mem[task_q] <= a_eff;
        lvl_mem[task_q]   <= LvlW'(1);
        if (count_q[0] < CW'(MAX_TASKS))
          fifo_mem[0][tail_of(head_q[0], count_q[0])] <= task_q;
      end
      S_WRITE: if (run_q != '0) begin
        done_mem[task_q] <= wd_q + run_final;
        if (run_final != left_q && al_after == '0) begin
          allot_mem[task_q] <= a_eff;
          lvl_mem[task_q]   <= (lvl_q < LvlW'(3)) ? lvl_q + LvlW'(1) : lvl_q;
        end else begin
          allot_mem[task_q] <= al_after;
        end
        if (run_final != left_q) begin
          if (al_after == '0 && lvl_q != LvlW'(3)) begin
            if (count_q[lvl_q] < CW'(MAX_TASKS))
              fifo_mem[lvl_q][tail_of(head_q[lvl_q], count_q[lvl_q])] <= task_q;
          end else if (count_q[lvl_q-LvlW'(1)] < CW'(MAX_TASKS)) begin
            fifo_mem[lvl_q-LvlW'(1)][tail_of(head_q[lvl_q-LvlW'(1)],
                count_q[lvl_q-LvlW'(1)])] <= task_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer: state, pointers, busy table and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_busy_q <= '0;
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0;
        count_q[i] <= '0;
      end
      qsel_q <= '0; run_q <= '0; done_q <= 1'b0;
      res_task_q <= '0; res_run_q <= '0; res_ev_q <= EV_IDLE; res_lvl_q <= LvlW'(1);
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          unique case (command_i)
            CMD_ADD:      state_q <= S_ADD;
            CMD_DISPATCH: state_q <= S_PICK;
            CMD_BOOST:    state_q <= S_BST_POP;
            default:      state_q <= S_DONE;
          endcase
          res_task_q <= '0; res_run_q <= '0; res_ev_q <= EV_IDLE; res_lvl_q <= LvlW'(1);
          if (command_i == CMD_BOOST) res_ev_q <= EV_BOOSTED;
          qsel_q <= (command_i == CMD_BOOST) ? 2'd1
                  : (count_q[0] != '0) ? 2'd0 : (count_q[1] != '0) ? 2'd1 : 2'd2;
        end
        S_ADD: begin
          res_task_q <= id_q;
          if (!id_ok) res_ev_q <= EV_BUSY;
          else if (slot_busy_q[AW'(id_q)]) begin
            res_ev_q <= EV_BUSY; res_lvl_q <= lvl_mem[AW'(id_q)];
          end else begin
            res_ev_q <= EV_ADDED;
            slot_busy_q[AW'(id_q)] <= 1'b1;
            if (count_q[0] < CW'(MAX_TASKS)) count_q[0] <= count_q[0] + CW'(1);
          end
          state_q <= S_DONE;
        end
        S_PICK: begin
          if (count_q[qsel_q] == '0) state_q <= S_DONE;
          else begin
            head_q[qsel_q]  <= inc(head_q[qsel_q]);
            count_q[qsel_q] <= count_q[qsel_q] - CW'(1);
            state_q <= S_RDTASK;
          end
        end
        S_RDTASK: state_q <= S_CALC;
        S_CALC: begin
          res_task_q <= IdW'(task_q);
          res_lvl_q  <= lvl_q;
          if (tot_q <= wd_q) begin
            slot_busy_q[task_q] <= 1'b0;
            res_ev_q <= EV_FINISHED;
            state_q <= S_DONE;
          end else begin
            // left_q loads this cycle; the minimum is taken on the next one
            run_q <= '0;
            state_q <= S_WRITE;
          end
        end
        S_DIV: if (div_rsp.done) begin
          run_q <= div_rem + WorkW'(1);
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (run_q == '0) begin
            // First pass: minimum ready now that left_q is loaded.
            run_q <= mn2;
            if (draw_q <= pct_q) state_q <= S_DIV;
            else state_q <= S_WRITE;
          end else begin
            res_run_q <= run_final;
            if (run_final == left_q) begin
              slot_busy_q[task_q] <= 1'b0;
              res_ev_q <= EV_FINISHED;
            end else begin
              if (al_after == '0) begin
                res_ev_q <= EV_DEMOTED;
                if (lvl_q < LvlW'(3)) res_lvl_q <= lvl_q + LvlW'(1);
              end else res_ev_q <= EV_REQUEUED;
              if (al_after == '0 && lvl_q != LvlW'(3)) begin
                if (count_q[lvl_q] < CW'(MAX_TASKS))
                  count_q[lvl_q] <= count_q[lvl_q] + CW'(1);
              end else if (count_q[lvl_q-LvlW'(1)] < CW'(MAX_TASKS)) begin
                count_q[lvl_q-LvlW'(1)] <= count_q[lvl_q-LvlW'(1)] + CW'(1);
              end
            end
            state_q <= S_DONE;
          end
        end
        S_BST_POP: begin
          if (count_q[qsel_q] == '0) begin
            if (qsel_q == 2'd1) qsel_q <= 2'd2;
            else state_q <= S_DONE;
          end else begin
            head_q[qsel_q]  <= inc(head_q[qsel_q]);
            count_q[qsel_q] <= count_q[qsel_q] - CW'(1);
            state_q <= S_BST_PUSH;
          end
        end
        S_BST_PUSH: begin
          if (cmd_q == CMD_BOOST) begin
            if (count_q[0] < CW'(MAX_TASKS)) count_q[0] <= count_q[0] + CW'(1);
            state_q <= S_BST_POP;
          end else state_q <= S_BST_POP;
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign served_task_o = res_task_q;
  assign run_time_o    = res_run_q;
  assign event_res_o   = res_ev_q;
  assign new_level_o   = res_lvl_q;

`ifndef SYNTHESIS
  // A result strobe is a single cycle and always follows the last step.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_DONE)) else $error("result without done step");
  a_level_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[0] <= CW'(MAX_TASKS)) else $error("level-1 count overflow");
`endif
endmodule
`default_nettype wire
